[rtl/tal_pkg.sv]
`default_nettype none
package tal_pkg;

  // Node numbers are 10 bits; the node count follows from that width.
  localparam int NODE_W  = 10;
  localparam int NODES   = 1 << NODE_W;
  localparam int LEVELS  = 10;
  localparam int DEPTH_W = 10;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_AW  = NODE_W + LVL_W;
  // Depth plus a lift step of up to 2^(LEVELS-1), with a carry bit
  localparam int STEP_W  = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

  typedef enum logic [1:0] {
    KIND_ROOT   = 2'd0,
    KIND_ATTACH = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROOT,
    ST_ATT0,
    ST_ATTD,
    ST_ATTL,
    ST_QD0,
    ST_QD1,
    ST_QD2,
    ST_LCHK,
    ST_LANC,
    ST_LDEP,
    ST_QEQ,
    ST_URX,
    ST_URY,
    ST_UCMP,
    ST_FRD,
    ST_FWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              re;
    logic [ANC_AW-1:0] raddr;
    logic              we;
    logic [ANC_AW-1:0] waddr;
    logic [NODE_W-1:0] wdata;
  } anc_req_t;

  typedef struct packed {
    logic               re;
    logic [NODE_W-1:0]  raddr;
    logic               we;
    logic [NODE_W-1:0]  waddr;
    logic [DEPTH_W-1:0] wdata;
  } dep_req_t;

endpackage
`default_nettype wire

[rtl/tal_ram.sv]
`default_nettype none
module tal_ram #(
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read; same-address write is forwarded.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/tal_ctrl.sv]
`default_nettype none
module tal_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [tal_pkg::NODE_W-1:0]  node_a_i,
  input  wire logic [tal_pkg::NODE_W-1:0]  node_b_i,
  input  wire logic                        out_free_i,
  output logic                             res_valid_o,
  output logic [tal_pkg::NODE_W-1:0]       res_data_o,
  output tal_pkg::anc_req_t                anc_req_o,
  input  wire logic [tal_pkg::NODE_W-1:0]  anc_rdata_i,
  output tal_pkg::dep_req_t                dep_req_o,
  input  wire logic [tal_pkg::DEPTH_W-1:0] dep_rdata_i
);

  localparam logic [tal_pkg::LVL_W-1:0] LVL_TOP = tal_pkg::LVL_W'(tal_pkg::LEVELS - 1);
  localparam logic [tal_pkg::LVL_W-1:0] LVL_ONE = tal_pkg::LVL_W'(1);
  localparam logic [tal_pkg::LVL_W-1:0] LVL_ZERO = '0;

  tal_pkg::state_e st_q, st_d;

  logic [tal_pkg::NODE_W-1:0]  x_q, x_d, y_q, y_d, tx_q, tx_d;
  logic [tal_pkg::DEPTH_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [tal_pkg::LVL_W-1:0]   lvl_q, lvl_d;

  logic                        accept;
  logic [tal_pkg::STEP_W-1:0]  step;
  logic [tal_pkg::STEP_W-1:0]  need;
  logic                        take;
  logic                        differ;
  logic [tal_pkg::NODE_W-1:0]  nx;

  assign accept = req_valid_i && req_ready_o;

  // Shared compare: lift when the deeper node is at least 2^lvl below the other
  assign step   = tal_pkg::STEP_W'(1) << lvl_q;
  assign need   = tal_pkg::STEP_W'(dy_q) + step;
  assign take   = tal_pkg::STEP_W'(dx_q) >= need;
  assign differ = tx_q != anc_rdata_i;
  assign nx     = differ ? tx_q : x_q;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      tal_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          case (tal_pkg::kind_e'(kind_i))
            tal_pkg::KIND_ROOT:   st_d = tal_pkg::ST_ROOT;
            tal_pkg::KIND_ATTACH: st_d = tal_pkg::ST_ATT0;
            tal_pkg::KIND_QUERY:  st_d = tal_pkg::ST_QD0;
            default:              st_d = tal_pkg::ST_IDLE;
          endcase
        end
      end
      tal_pkg::ST_ROOT: if (lvl_q == LVL_TOP) st_d = tal_pkg::ST_IDLE;
      tal_pkg::ST_ATT0: st_d = tal_pkg::ST_ATTD;
      tal_pkg::ST_ATTD: st_d = (tal_pkg::LEVELS > 1) ? tal_pkg::ST_ATTL : tal_pkg::ST_IDLE;
      tal_pkg::ST_ATTL: if (lvl_q == LVL_TOP) st_d = tal_pkg::ST_IDLE;
      tal_pkg::ST_QD0:  st_d = tal_pkg::ST_QD1;
      tal_pkg::ST_QD1:  st_d = tal_pkg::ST_QD2;
      tal_pkg::ST_QD2:  st_d = tal_pkg::ST_LCHK;
      tal_pkg::ST_LCHK: begin
        if (take) begin
          st_d = tal_pkg::ST_LANC;
        end else if (lvl_q == LVL_ZERO) begin
          st_d = tal_pkg::ST_QEQ;
        end
      end
      tal_pkg::ST_LANC: st_d = tal_pkg::ST_LDEP;
      tal_pkg::ST_LDEP: st_d = (lvl_q == LVL_ZERO) ? tal_pkg::ST_QEQ : tal_pkg::ST_LCHK;
      tal_pkg::ST_QEQ:  st_d = (x_q == y_q) ? tal_pkg::ST_DONE : tal_pkg::ST_URX;
      tal_pkg::ST_URX:  st_d = tal_pkg::ST_URY;
      tal_pkg::ST_URY:  st_d = tal_pkg::ST_UCMP;
      tal_pkg::ST_UCMP: st_d = (lvl_q == LVL_ZERO) ? tal_pkg::ST_FRD : tal_pkg::ST_URY;
      tal_pkg::ST_FRD:  st_d = tal_pkg::ST_FWAIT;
      tal_pkg::ST_FWAIT: st_d = tal_pkg::ST_DONE;
      tal_pkg::ST_DONE: if (out_free_i) st_d = tal_pkg::ST_IDLE;
      default:          st_d = tal_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    tx_d  = tx_q;
    dx_d  = dx_q;
    dy_d  = dy_q;
    lvl_d = lvl_q;
    anc_req_o = '0;
    dep_req_o = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_data_o  = x_q;
    case (st_q)
      tal_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          x_d   = node_a_i;
          y_d   = node_b_i;
          lvl_d = LVL_ZERO;
        end
      end
      tal_pkg::ST_ROOT: begin
        anc_req_o.we    = 1'b1;
        anc_req_o.waddr = {x_q, lvl_q};
        anc_req_o.wdata = x_q;
        dep_req_o.we    = 1'b1;
        dep_req_o.waddr = x_q;
        dep_req_o.wdata = '0;
        lvl_d = lvl_q + LVL_ONE;
      end
      tal_pkg::ST_ATT0: begin
        anc_req_o.we    = 1'b1;
        anc_req_o.waddr = {y_q, LVL_ZERO};
        anc_req_o.wdata = x_q;
        anc_req_o.re    = 1'b1;
        anc_req_o.raddr = {x_q, LVL_ZERO};
        dep_req_o.re    = 1'b1;
        dep_req_o.raddr = x_q;
        lvl_d = LVL_ONE;
      end
      tal_pkg::ST_ATTD: begin
        dep_req_o.we    = 1'b1;
        dep_req_o.waddr = y_q;
        dep_req_o.wdata = dep_rdata_i + tal_pkg::DEPTH_W'(1);
      end
      tal_pkg::ST_ATTL: begin
        anc_req_o.we    = 1'b1;
        anc_req_o.waddr = {y_q, lvl_q};
        anc_req_o.wdata = anc_rdata_i;
        if (lvl_q != LVL_TOP) begin
          anc_req_o.re    = 1'b1;
          anc_req_o.raddr = {anc_rdata_i, lvl_q};
          lvl_d = lvl_q + LVL_ONE;
        end
      end
      tal_pkg::ST_QD0: begin
        dep_req_o.re    = 1'b1;
        dep_req_o.raddr = x_q;
      end
      tal_pkg::ST_QD1: begin
        dep_req_o.re    = 1'b1;
        dep_req_o.raddr = y_q;
        dx_d = dep_rdata_i;
      end
      tal_pkg::ST_QD2: begin
        // Keep the deeper node in x
        if (dx_q < dep_rdata_i) begin
          x_d  = y_q;
          y_d  = x_q;
          dx_d = dep_rdata_i;
          dy_d = dx_q;
        end else begin
          dy_d = dep_rdata_i;
        end
        lvl_d = LVL_TOP;
      end
      tal_pkg::ST_LCHK: begin
        if (take) begin
          anc_req_o.re    = 1'b1;
          anc_req_o.raddr = {x_q, lvl_q};
        end else if (lvl_q != LVL_ZERO) begin
          lvl_d = lvl_q - LVL_ONE;
        end
      end
      tal_pkg::ST_LANC: begin
        x_d = anc_rdata_i;
        dep_req_o.re    = 1'b1;
        dep_req_o.raddr = anc_rdata_i;
      end
      tal_pkg::ST_LDEP: begin
        dx_d = dep_rdata_i;
        if (lvl_q != LVL_ZERO) begin
          lvl_d = lvl_q - LVL_ONE;
        end
      end
      tal_pkg::ST_QEQ: begin
        lvl_d = LVL_TOP;
      end
      tal_pkg::ST_URX: begin
        anc_req_o.re    = 1'b1;
        anc_req_o.raddr = {x_q, lvl_q};
      end
      tal_pkg::ST_URY: begin
        tx_d = anc_rdata_i;
        anc_req_o.re    = 1'b1;
        anc_req_o.raddr = {y_q, lvl_q};
      end
      tal_pkg::ST_UCMP: begin
        if (differ) begin
          x_d = tx_q;
          y_d = anc_rdata_i;
        end
        if (lvl_q != LVL_ZERO) begin
          anc_req_o.re    = 1'b1;
          anc_req_o.raddr = {nx, lvl_q - LVL_ONE};
          lvl_d = lvl_q - LVL_ONE;
        end
      end
      tal_pkg::ST_FRD: begin
        anc_req_o.re    = 1'b1;
        anc_req_o.raddr = {x_q, LVL_ZERO};
      end
      tal_pkg::ST_FWAIT: begin
        x_d = anc_rdata_i;
      end
      tal_pkg::ST_DONE: begin
        res_valid_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= tal_pkg::ST_IDLE;
      lvl_q <= '0;
    end else begin
      st_q  <= st_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    tx_q <= tx_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

`ifndef ASSERT_OFF
  // Query lift and climb states never write the ancestor or depth table
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == tal_pkg::ST_LCHK || st_q == tal_pkg::ST_LANC || st_q == tal_pkg::ST_URX ||
     st_q == tal_pkg::ST_URY || st_q == tal_pkg::ST_UCMP || st_q == tal_pkg::ST_FRD)
    |-> !anc_req_o.we && !dep_req_o.we)
    else $error("table written during query");

  a_res_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result issued while output busy");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == tal_pkg::KIND_QUERY) |=> st_q == tal_pkg::ST_QD0)
    else $error("query did not start with depth read");

  a_result_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> st_q == tal_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after result");

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != tal_pkg::ST_IDLE |-> lvl_q <= LVL_TOP)
    else $error("level counter out of range");
`endif

endmodule
`default_nettype wire

[rtl/tree_ancestor_lca_engine.sv]
`default_nettype none
// Channel   Dir  tdata                              tuser
// s_axis    in   [9:0] node_a, [19:10] node_b       [1:0] kind
// m_axis    out  [9:0] ancestor                     -
//
// One request at a time; s_axis_tready is high only while the sequencer idles.
// Root: one table write per level. Attach: one table write and one dependent
// table read per level on the table's write and read ports. Query: accept and
// depth reads, a depth lift (table then depth read), an equality check and first
// read, a pairwise climb (two table reads per level) and a final parent read.
// Reset clears only control state; table and depth memories are not cleared.
// A finished query holds in the sequencer until the output register is free.
module tree_ancestor_lca_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [9:0] node_a, [19:10] node_b, rest zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [9:0] ancestor, rest zero
);

  tal_pkg::anc_req_t                anc_req;
  tal_pkg::dep_req_t                dep_req;
  logic [tal_pkg::NODE_W-1:0]       anc_rdata;
  logic [tal_pkg::DEPTH_W-1:0]      dep_rdata;
  logic                             out_free;
  logic                             res_valid;
  logic [tal_pkg::NODE_W-1:0]       res_data;

  logic                             m_valid_q, m_valid_d;
  logic [tal_pkg::NODE_W-1:0]       m_data_q;

  // Output register frees up in the same cycle it is taken
  assign out_free = !m_valid_q || m_axis_tready;

  tal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .node_a_i    (s_axis_tdata[tal_pkg::NODE_W-1:0]),
    .node_b_i    (s_axis_tdata[2*tal_pkg::NODE_W-1:tal_pkg::NODE_W]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .anc_req_o   (anc_req),
    .anc_rdata_i (anc_rdata),
    .dep_req_o   (dep_req),
    .dep_rdata_i (dep_rdata)
  );

  // Ancestor table: address is {node, level}
  tal_ram #(
    .AW (tal_pkg::ANC_AW),
    .DW (tal_pkg::NODE_W)
  ) u_anc_ram (
    .clk_i   (clk_i),
    .re_i    (anc_req.re),
    .raddr_i (anc_req.raddr),
    .we_i    (anc_req.we),
    .waddr_i (anc_req.waddr),
    .wdata_i (anc_req.wdata),
    .rdata_o (anc_rdata)
  );

  // Node depths
  tal_ram #(
    .AW (tal_pkg::NODE_W),
    .DW (tal_pkg::DEPTH_W)
  ) u_dep_ram (
    .clk_i   (clk_i),
    .re_i    (dep_req.re),
    .raddr_i (dep_req.raddr),
    .we_i    (dep_req.we),
    .waddr_i (dep_req.waddr),
    .wdata_i (dep_req.wdata),
    .rdata_o (dep_rdata)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(16 - tal_pkg::NODE_W){1'b0}}, m_data_q};

endmodule
`default_nettype wire

[tb/sv/tree_ancestor_lca_checker.sv]
`default_nettype none
module tree_ancestor_lca_checker
  import tal_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      answers_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the lifting table and the depths
  logic [NODE_W-1:0]  anc_tbl   [NODES][LEVELS];
  logic [DEPTH_W-1:0] depth_tbl [NODES];

  logic [NODE_W-1:0] ancestor_q [$];
  int unsigned       fails   = 0;
  int unsigned       answers = 0;

  initial begin
    foreach (depth_tbl[n]) begin
      depth_tbl[n] = '0;
      for (int lv = 0; lv < LEVELS; lv++) anc_tbl[n][lv] = '0;
    end
  end

  task automatic make_root(input logic [NODE_W-1:0] node);
    for (int lv = 0; lv < LEVELS; lv++) anc_tbl[node][lv] = node;
    depth_tbl[node] = '0;
  endtask

  // Level 0 first, each higher level from the ones already written;
  // the parent depth is read before the child depth is written.
  task automatic attach_child(input logic [NODE_W-1:0] parent, input logic [NODE_W-1:0] child);
    logic [DEPTH_W-1:0] d;
    d = depth_tbl[parent] + 1'b1;
    anc_tbl[child][0] = parent;
    for (int lv = 1; lv < LEVELS; lv++)
      anc_tbl[child][lv] = anc_tbl[anc_tbl[child][lv-1]][lv-1];
    depth_tbl[child] = d;
  endtask

  function automatic logic [NODE_W-1:0] lowest_common(input logic [NODE_W-1:0] na,
                                                      input logic [NODE_W-1:0] nb);
    logic [NODE_W-1:0] x, y, t;
    x = na;
    y = nb;
    if (depth_tbl[x] < depth_tbl[y]) begin
      t = x;
      x = y;
      y = t;
    end
    // lift the deeper node, re-reading its depth after every step
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (int'(depth_tbl[x]) >= int'(depth_tbl[y]) + (1 << lv)) x = anc_tbl[x][lv];
    end
    if (x == y) return x;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (anc_tbl[x][lv] != anc_tbl[y][lv]) begin
        x = anc_tbl[x][lv];
        y = anc_tbl[y][lv];
      end
    end
    return anc_tbl[x][0];
  endfunction

  always @(posedge clk_i) begin
    logic [NODE_W-1:0] want, got, na, nb;
    if (rst_ni) begin
      // results first, so a request and a result on one edge keep their order
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[NODE_W-1:0];
        answers++;
        if (ancestor_q.size() == 0) begin
          $error("ancestor result %0d with no query outstanding", got);
          fails++;
        end else begin
          want = ancestor_q.pop_front();
          if (want !== got) begin
            $error("ancestor mismatch: expected %0d, actual %0d", want, got);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        na = s_axis_tdata[NODE_W-1:0];
        nb = s_axis_tdata[2*NODE_W-1:NODE_W];
        case (kind_e'(s_axis_tuser))
          KIND_ROOT:   make_root(na);
          KIND_ATTACH: attach_child(na, nb);
          KIND_QUERY:  ancestor_q = {ancestor_q, lowest_common(na, nb)};
          default: ;
        endcase
      end
    end
    errors_o  <= fails;
    pending_o <= ancestor_q.size();
    answers_o <= answers;
  end

endmodule
`default_nettype wire

[tb/sv/tree_ancestor_lca_engine_tb.sv]
`default_nettype none
module tree_ancestor_lca_engine_tb;
  import tal_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 200;
  localparam int CHAIN_LEN    = 520;   // deep enough for a lift at every level
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the engine
  localparam int TAIL_CYCLES  = 80;    // margin after the longest query

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = KIND_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int unsigned fail_cnt, pending_cnt, answer_cnt;

  // idle rates in percent; sink rate is read by the receiver process
  int unsigned src_gap_pct  = 15;
  int unsigned sink_gap_pct = 61;

  logic        hold_off_go   = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned hold_count    = 0;

  int unsigned n_root = 0, n_attach = 0, n_query = 0, n_none = 0;

  always #4 clk_i = ~clk_i;

  tree_ancestor_lca_engine DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  tree_ancestor_lca_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors_o     (fail_cnt),
    .pending_o    (pending_cnt),
    .answers_o    (answer_cnt)
  );

  // Receiver: random back-pressure, plus one long hold-off on request from
  // the stimulus. The hold-off counts its own cycles so the sender keeps
  // pushing requests into a stalled engine.
  always @(posedge clk_i) begin
    if (hold_off_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  // One request on the slave side. Called at a rising edge, returns at the
  // edge that accepted it with tvalid still high, so back-to-back requests
  // never drop and re-raise tvalid in one step.
  task automatic send_request(input kind_e k, input logic [NODE_W-1:0] na,
                              input logic [NODE_W-1:0] nb);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, nb, na};
    s_axis_tuser  <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (k)
      KIND_ROOT:   n_root++;
      KIND_ATTACH: n_attach++;
      KIND_QUERY:  n_query++;
      default:     n_none++;
    endcase
  endtask

  // Sender goes quiet until every outstanding query has answered
  task automatic wait_for_answers();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  function automatic logic [NODE_W-1:0] any_node();
    return NODE_W'($urandom_range(NODES - 1));
  endfunction

  // A node the chain has written
  function automatic logic [NODE_W-1:0] any_known();
    return NODE_W'($urandom_range(CHAIN_LEN - 1));
  endfunction

  initial begin
    logic [NODE_W-1:0] grove [$];   // members of the tree built in the current round
    logic [NODE_W-1:0] x, y;
    int unsigned       counted, round_len, pick;
    logic              calm;

    counted = 0;
    calm    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: small tree at the node-number extremes ----
    send_request(KIND_ROOT,   10'd0,    10'd0);
    send_request(KIND_ATTACH, 10'd0,    10'd1023);
    send_request(KIND_ATTACH, 10'd1023, 10'd512);
    send_request(KIND_ATTACH, 10'd512,  10'd341);  // alternating bit patterns
    send_request(KIND_ATTACH, 10'd512,  10'd682);
    send_request(KIND_QUERY,  10'd341,  10'd682);  // siblings
    send_request(KIND_QUERY,  10'd682,  10'd0);    // one is the other's ancestor
    send_request(KIND_QUERY,  10'd0,    10'd341);  // first node shallower
    send_request(KIND_QUERY,  10'd1023, 10'd1023); // same node
    // unused kind changes nothing
    send_request(KIND_NONE,   10'd1023, 10'd1023);
    send_request(KIND_NONE,   10'd0,    10'd0);
    send_request(KIND_NONE,   any_node(), any_node());
    // second tree, query across trees
    send_request(KIND_ROOT,   10'd5,    10'd1023);
    send_request(KIND_QUERY,  10'd5,    10'd341);
    // self attach: table reads its own fresh level 0
    send_request(KIND_ATTACH, 10'd682,  10'd682);
    send_request(KIND_QUERY,  10'd682,  10'd341);
    // re-attach under a different parent
    send_request(KIND_ATTACH, 10'd0,    10'd341);
    send_request(KIND_QUERY,  10'd341,  10'd682);
    // re-root a middle node, then close a cycle through the old root
    send_request(KIND_ROOT,   10'd512,  10'd0);
    send_request(KIND_QUERY,  10'd682,  10'd341);
    send_request(KIND_ATTACH, 10'd341,  10'd0);
    send_request(KIND_QUERY,  10'd0,    10'd1023);
    wait_for_answers();

    // ---- chain: lifts at every level, then a self attach at the bottom ----
    send_request(KIND_ROOT, 10'd0, 10'd0);
    for (int i = 1; i < CHAIN_LEN; i++) begin
      send_request(KIND_ATTACH, NODE_W'(i - 1), NODE_W'(i));
      if (i % 97 == 0) send_request(KIND_QUERY, NODE_W'(i), NODE_W'($urandom_range(i)));
    end
    send_request(KIND_QUERY,  NODE_W'(CHAIN_LEN - 1),     10'd0);
    send_request(KIND_QUERY,  NODE_W'(CHAIN_LEN - 1),     NODE_W'(CHAIN_LEN - 2));
    send_request(KIND_QUERY,  NODE_W'(CHAIN_LEN / 2 - 1), NODE_W'(CHAIN_LEN - 1));
    send_request(KIND_QUERY,  NODE_W'(CHAIN_LEN * 3 / 4), 10'd300);
    send_request(KIND_ATTACH, NODE_W'(CHAIN_LEN - 1),     NODE_W'(CHAIN_LEN - 1));
    send_request(KIND_QUERY,  NODE_W'(CHAIN_LEN - 1),     NODE_W'(CHAIN_LEN - 2));
    send_request(KIND_QUERY,  10'd0,                      NODE_W'(CHAIN_LEN - 1));
    send_request(KIND_QUERY,  10'd300,                    NODE_W'(CHAIN_LEN - 1));

    // ---- random: queries stay on chain nodes or the current tree ----
    src_gap_pct = 61;
    sink_gap_pct <= 15;
    hold_off_go  <= 1'b1;
    while (counted < RANDOM_ITEMS) begin
      if (!calm && counted >= RANDOM_ITEMS / 2) begin
        wait_for_answers();
        src_gap_pct = 0;
        sink_gap_pct <= 0;
        calm = 1'b1;
      end
      // a fresh tree per round, grown and queried with random content
      x = any_node();
      send_request(KIND_ROOT, x, any_node());
      counted++;
      grove.delete();
      grove = {grove, x};
      round_len = $urandom_range(40, 4);
      for (int j = 0; j < round_len && counted < RANDOM_ITEMS; j++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          // mostly new children, sometimes a re-attach inside the tree
          y = ($urandom_range(9) == 0) ? grove[$urandom_range(grove.size() - 1)] : any_node();
          x = grove[$urandom_range(grove.size() - 1)];
          send_request(KIND_ATTACH, x, y);
          grove = {grove, y};
          counted++;
        end else if (pick < 88) begin
          x = grove[$urandom_range(grove.size() - 1)];
          y = ($urandom_range(9) == 0) ? any_known() : grove[$urandom_range(grove.size() - 1)];
          send_request(KIND_QUERY, x, y);
          counted++;
        end else if (pick < 94) begin
          send_request(KIND_NONE, any_node(), any_node());
        end else begin
          send_request(KIND_QUERY, any_known(), any_known());
          counted++;
        end
      end
    end

    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d root, %0d attach, %0d query and %0d unused-kind requests;",
             n_root, n_attach, n_query, n_none);
    $display("%0d ancestors checked, including a %0d-node chain with lifts at every level.",
             answer_cnt, CHAIN_LEN);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Timeout with %0d queries outstanding", pending_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/tal_pkg.sv
rtl/tal_ram.sv
rtl/tal_ctrl.sv
rtl/tree_ancestor_lca_engine.sv
tb/sv/tree_ancestor_lca_checker.sv
tb/sv/tree_ancestor_lca_engine_tb.sv
